[rtl/duart_pkg.sv]
// Package for the dual UART register model: widths, command and register codes.
// No dependencies.
package duart_pkg;
	localparam int RxDepth   = 16;
	localparam int TxDepth   = 16;
	localparam int TickWidth = 32;
	localparam int RxAw      = $clog2(RxDepth);
	localparam int TxAw      = $clog2(TxDepth);
	localparam int RxCw      = $clog2(RxDepth + 1);
	localparam int TxCw      = $clog2(TxDepth + 1);
	localparam int SumWidth  = (TickWidth > 32 ? TickWidth : 32) + 1;

	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_LRX   = 3'd2;
	localparam logic [2:0] CMD_LTX   = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	localparam logic [2:0] REG_MR   = 3'd0;
	localparam logic [2:0] REG_SR   = 3'd1;
	localparam logic [2:0] REG_CR   = 3'd2;
	localparam logic [2:0] REG_FIFO = 3'd3;
	localparam logic [3:0] REG_ACR  = 4'd4;
	localparam logic [3:0] REG_ISR  = 4'd5;
	localparam logic [3:0] REG_CTU  = 4'd6;
	localparam logic [3:0] REG_CTL  = 4'd7;
	localparam logic [3:0] REG_IVR  = 4'd12;
	localparam logic [3:0] REG_OPC  = 4'd13;
	localparam logic [3:0] REG_STRT = 4'd14;
	localparam logic [3:0] REG_STOP = 4'd15;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] register_address;
		logic [7:0] write_data;
		logic       line_channel;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       line_valid;
		logic [7:0] line_byte;
		logic       irq;
	} rsp_t;

	// divider control
	typedef struct packed {
		logic                start;
		logic [SumWidth-1:0] dividend;
		logic [16:0]         divisor;
	} div_req_t;
endpackage

[rtl/duart_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on duart_pkg.
interface duart_req_if;
	logic valid;
	logic ready;
	duart_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface duart_rsp_if;
	logic valid;
	logic ready;
	duart_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/duart_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module duart_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[rtl/duart_div.sv]
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on duart_pkg.
module duart_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  duart_pkg::div_req_t           req,
	output logic                          done,
	output logic [16:0]                   rem
);
	import duart_pkg::*;
	localparam int CntW = $clog2(SumWidth + 1);

	logic [SumWidth-1:0] dvd_q;
	logic [17:0]         rem_q;
	logic [16:0]         dvs_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic [17:0]         shifted;
	logic [17:0]         diff;

	assign shifted = {rem_q[16:0], dvd_q[SumWidth-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(SumWidth);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SumWidth-2:0], 1'b0};
			rem_q <= diff[17] ? shifted : diff;
		end
	end

	assign done = !busy_q && !req.start;
	assign rem  = rem_q[16:0];
endmodule

[rtl/dual_uart_register_model_core.sv]
// Top level of the dual UART register model: registers, FIFOs, sequencer.
// Depends on duart_pkg, duart_if, duart_ram, duart_div.
// Flow: an accepted item passes ST_MEM and ST_WAIT before its result is valid in ST_OUT;
// counter reads (6/7) also wait in ST_DIV for the serial remainder unit.
// Ready is low while an item is processed or its result waits, so a new item is taken
// only once the last result has been accepted. Reset: asynchronous active-low;
// all control state cleared, vector 0x0F, preset 0xFFFF. FIFO storage is not cleared.
module dual_uart_register_model_core (
	input  logic clk,
	input  logic arst_n,
	duart_req_if.sink   req,
	duart_rsp_if.source rsp
);
	import duart_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MEM  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	req_t   req_q;

	logic [RxAw-1:0] rx_head_q [2], rx_tail_q [2];
	logic [TxAw-1:0] tx_head_q [2], tx_tail_q [2];
	logic [RxCw-1:0] rx_cnt_q [2];
	logic [TxCw-1:0] tx_cnt_q [2];
	logic [7:0] mr1_q [2], mr2_q [2], csr_q [2];
	logic       mrp_q [2], rxen_q [2], txen_q [2];
	logic [7:0] acr_q, imr_q, ivr_q, opc_q;
	logic [15:0] preset_q;
	logic        run_q;
	logic [TickWidth-1:0] ticks_q;
	logic [31:0] phase_q;
	rsp_t        out_q;

	logic        ch;
	logic [2:0]  lo;
	logic [7:0]  isr;
	logic        loop [2];
	logic [7:0]  stat [2];

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			loop[c] = (mr2_q[c] & 8'hC0) == 8'h80;
			stat[c] = {4'b0, tx_cnt_q[c] == '0, txen_q[c], rx_cnt_q[c] >= RxCw'(3),
				rx_cnt_q[c] != '0};
		end
		isr = {2'b0, stat[1][0], stat[1][2], 2'b0, stat[0][0], stat[0][2]};
	end

	assign ch = req_q.command == CMD_READ || req_q.command == CMD_WRITE ?
		req_q.register_address[3] : req_q.line_channel;
	assign lo = req_q.register_address[2:0];

	// FIFO memories, one per channel and direction
	logic            rx_we [2], tx_we [2];
	logic [RxAw-1:0] rx_addr [2];
	logic [TxAw-1:0] tx_addr [2];
	logic [7:0]      rx_rd [2], tx_rd [2];

	logic is_bus_rd, is_bus_wr, tx_wr, rx_pop, line_rx, line_tx;
	assign is_bus_rd = req_q.command == CMD_READ;
	assign is_bus_wr = req_q.command == CMD_WRITE;
	assign tx_wr   = is_bus_wr && lo == REG_FIFO;
	assign rx_pop  = is_bus_rd && lo == REG_FIFO;
	assign line_rx = req_q.command == CMD_LRX;
	assign line_tx = req_q.command == CMD_LTX;

	logic push_rx, push_tx;
	assign push_rx = state_q == ST_MEM && ((tx_wr && loop[ch]) || (line_rx && !loop[ch]))
		&& rx_cnt_q[ch] < RxCw'(RxDepth);
	assign push_tx = state_q == ST_MEM && tx_wr && !loop[ch] && tx_cnt_q[ch] < TxCw'(TxDepth);

	for (genvar g = 0; g < 2; g++) begin : g_fifo
		assign rx_we[g]   = push_rx && ch == 1'(g);
		assign tx_we[g]   = push_tx && ch == 1'(g);
		assign rx_addr[g] = rx_we[g] ? rx_head_q[g] : rx_tail_q[g];
		assign tx_addr[g] = tx_we[g] ? tx_head_q[g] : tx_tail_q[g];
		duart_ram #(.Width(8), .Depth(RxDepth)) u_rx (.clk, .we(rx_we[g]),
			.addr(rx_addr[g]), .wdata(req_q.write_data), .rdata(rx_rd[g]));
		duart_ram #(.Width(8), .Depth(TxDepth)) u_tx (.clk, .we(tx_we[g]),
			.addr(tx_addr[g]), .wdata(req_q.write_data), .rdata(tx_rd[g]));
	end

	// counter remainder
	div_req_t        dreq;
	logic            ddone;
	logic [16:0]     drem;
	logic [31:0]     phase_n;
	logic [16:0]     cval;
	assign phase_n = phase_q + 32'd1;
	assign dreq.start    = state_q == ST_MEM && is_bus_rd &&
		(req_q.register_address == REG_CTU || req_q.register_address == REG_CTL);
	assign dreq.dividend = SumWidth'(phase_n) + (run_q ? SumWidth'(ticks_q) : '0);
	assign dreq.divisor  = preset_q == '0 ? 17'h10000 : {1'b0, preset_q} + 17'd1;
	duart_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .rem(drem));
	assign cval = {1'b0, preset_q} - drem;

	function automatic logic en_next(logic [1:0] f, logic cur);
		en_next = f == 2'd1 ? 1'b1 : (f == 2'd2 ? 1'b0 : cur);
	endfunction

	// MR read uses the pointer before it advances
	logic [7:0] mr_rd;
	assign mr_rd = is_bus_rd && lo == REG_MR ? (mrp_q[ch] ? mr2_q[ch] : mr1_q[ch]) : '0;

	assign req.ready   = state_q == ST_IDLE;
	assign rsp.valid   = state_q == ST_OUT;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_q <= req.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int c = 0; c < 2; c++) begin
				rx_head_q[c] <= '0; rx_tail_q[c] <= '0; rx_cnt_q[c] <= '0;
				tx_head_q[c] <= '0; tx_tail_q[c] <= '0; tx_cnt_q[c] <= '0;
				mr1_q[c] <= '0; mr2_q[c] <= '0; csr_q[c] <= '0;
				mrp_q[c] <= 1'b0; rxen_q[c] <= 1'b0; txen_q[c] <= 1'b0;
			end
			acr_q    <= '0;
			imr_q    <= '0;
			ivr_q    <= 8'h0F;
			opc_q    <= '0;
			preset_q <= 16'hFFFF;
			run_q    <= 1'b0;
			ticks_q  <= '0;
			phase_q  <= '0;
			out_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (req.valid) state_q <= ST_MEM;
				ST_MEM: begin
					out_q <= {mr_rd, line_tx && tx_cnt_q[ch] != '0, 8'h00, 1'b0};
					state_q <= dreq.start ? ST_DIV : ST_WAIT;
					if (push_rx) begin
						rx_head_q[ch] <= rx_head_q[ch] == RxAw'(RxDepth - 1) ? '0
							: rx_head_q[ch] + 1'b1;
						rx_cnt_q[ch]  <= rx_cnt_q[ch] + 1'b1;
					end
					if (push_tx) begin
						tx_head_q[ch] <= tx_head_q[ch] == TxAw'(TxDepth - 1) ? '0
							: tx_head_q[ch] + 1'b1;
						tx_cnt_q[ch]  <= tx_cnt_q[ch] + 1'b1;
					end
					if (dreq.start) phase_q <= phase_n;
					if (req_q.command == CMD_TICK && run_q) ticks_q <= ticks_q + 1'b1;
					if (is_bus_rd) begin
						case (req_q.register_address)
							REG_STRT: begin run_q <= 1'b1; ticks_q <= '0; phase_q <= '0; end
							REG_STOP: run_q <= 1'b0;
							default: ;
						endcase
						if (lo == REG_MR) mrp_q[ch] <= 1'b1;
					end
					if (is_bus_wr) begin
						case (lo)
							REG_MR: begin
								if (mrp_q[ch]) mr2_q[ch] <= req_q.write_data;
								else mr1_q[ch] <= req_q.write_data;
								mrp_q[ch] <= 1'b1;
							end
							REG_SR: csr_q[ch] <= req_q.write_data;
							REG_CR: begin
								rxen_q[ch] <= en_next(req_q.write_data[1:0], rxen_q[ch]);
								txen_q[ch] <= en_next(req_q.write_data[3:2], txen_q[ch]);
								if (req_q.write_data[6:4] == 3'd1) mrp_q[ch] <= 1'b0;
								if (req_q.write_data[6:4] == 3'd2) begin
									rx_head_q[ch] <= '0; rx_tail_q[ch] <= '0;
									rx_cnt_q[ch] <= '0;
								end
							end
							default: ;
						endcase
						if (!req_q.register_address[3]) begin
							case (req_q.register_address)
								REG_ACR: acr_q <= req_q.write_data;
								REG_ISR: imr_q <= req_q.write_data;
								REG_CTU: preset_q[15:8] <= req_q.write_data;
								REG_CTL: preset_q[7:0] <= req_q.write_data;
								default: ;
							endcase
						end else begin
							case (req_q.register_address)
								REG_IVR: ivr_q <= req_q.write_data;
								REG_OPC: opc_q <= req_q.write_data;
								default: ;
							endcase
						end
					end
				end
				ST_DIV: if (ddone) state_q <= ST_WAIT;
				ST_WAIT: begin
					// RAM data of the tail read is now valid
					state_q <= ST_OUT;
					if (line_tx && out_q.line_valid) begin
						out_q.line_byte <= tx_rd[ch];
						tx_tail_q[ch] <= tx_tail_q[ch] == TxAw'(TxDepth - 1) ? '0
							: tx_tail_q[ch] + 1'b1;
						tx_cnt_q[ch] <= tx_cnt_q[ch] - 1'b1;
					end
					if (is_bus_rd) begin
						case (lo)
							REG_SR: out_q.read_data <= stat[ch];
							REG_FIFO: if (rx_cnt_q[ch] != '0) begin
								out_q.read_data <= rx_rd[ch];
								rx_tail_q[ch] <= rx_tail_q[ch] == RxAw'(RxDepth - 1) ? '0
									: rx_tail_q[ch] + 1'b1;
								rx_cnt_q[ch] <= rx_cnt_q[ch] - 1'b1;
							end
							default: ;
						endcase
						case (req_q.register_address)
							REG_ISR: out_q.read_data <= isr;
							REG_CTU: out_q.read_data <= cval[15:8];
							REG_CTL: out_q.read_data <= cval[7:0];
							REG_IVR: out_q.read_data <= ivr_q;
							REG_OPC, REG_STRT, REG_STOP: out_q.read_data <= 8'hFF;
							default: ;
						endcase
					end
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// irq after a pop must see the new counts; recompute on the way out
	logic irq_now;
	assign irq_now     = (isr & imr_q) != '0;
	assign rsp.payload = {out_q.read_data, out_q.line_valid, out_q.line_byte, irq_now};

	logic unused_ok;
	assign unused_ok = ^{acr_q, opc_q, csr_q[0], csr_q[1], rxen_q[0], rxen_q[1], rx_pop,
		out_q.irq};
endmodule

[bench/duart_tb_if.sv]
`timescale 1ns / 100ps
// Bench-side notes: the channel interfaces come from the RTL (rtl/duart_if.sv).
// This file holds the shared item helper package for the bench. Depends on duart_pkg.
package duart_tb_pkg;
	import duart_pkg::*;

	function automatic req_t make_item(logic [2:0] cmd, logic [3:0] addr, logic [7:0] data,
			logic ch);
		req_t r;
		r.command = cmd;
		r.register_address = addr;
		r.write_data = data;
		r.line_channel = ch;
		return r;
	endfunction
endpackage

[bench/duart_checker.sv]
`timescale 1ns / 100ps
// Checker for the dual UART register model: predicts every response from the
// accepted requests and compares it field by field. Depends on duart_pkg.
module duart_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  duart_pkg::req_t req_item,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  duart_pkg::rsp_t rsp_item,
	output int   errors,
	output int   pending
);
	import duart_pkg::*;

	logic [7:0] rx_mem [2][RxDepth];
	logic [7:0] tx_mem [2][TxDepth];
	int rx_head [2], rx_tail [2], rx_cnt [2];
	int tx_head [2], tx_tail [2], tx_cnt [2];
	logic [7:0] mode_reg [2][2];
	logic mode_ptr [2];
	logic rx_en [2], tx_en [2];
	logic [7:0] imr, ivr;
	logic [15:0] preset;
	logic running;
	logic [TickWidth-1:0] ticks;
	logic [31:0] phase;
	rsp_t expected_rsp [$];

	assign pending = expected_rsp.size();

	function automatic logic loopback(int c);
		return mode_reg[c][1][7:6] == 2'b10;
	endfunction

	function automatic logic [7:0] status_of(int c);
		return {4'h0, tx_cnt[c] == 0, tx_en[c], rx_cnt[c] >= 3, rx_cnt[c] > 0};
	endfunction

	function automatic logic [7:0] isr_of();
		logic [7:0] a, b;
		a = status_of(0);
		b = status_of(1);
		return {2'b00, b[0], b[2], 2'b00, a[0], a[2]};
	endfunction

	function automatic void rx_push(int c, logic [7:0] v);
		if (rx_cnt[c] < RxDepth) begin
			rx_mem[c][rx_head[c]] = v;
			rx_head[c] = (rx_head[c] + 1) % RxDepth;
			rx_cnt[c]++;
		end
	endfunction

	function automatic logic [15:0] counter_now();
		logic [63:0] sum, span;
		span = preset != 0 ? {48'd0, preset} + 1 : 64'h10000;
		sum = {32'd0, phase};
		if (running)
			sum += {{(64-TickWidth){1'b0}}, ticks};
		return preset - 16'(sum % span);
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t o;
		int c;
		logic [7:0] d;
		o = '0;
		d = r.write_data;
		case (r.command)
			CMD_READ: begin
				c = r.register_address[3];
				case (r.register_address)
					{1'b0, REG_MR}, {1'b1, REG_MR}: begin
						o.read_data = mode_reg[c][mode_ptr[c]];
						mode_ptr[c] = 1'b1;
					end
					{1'b0, REG_SR}, {1'b1, REG_SR}: o.read_data = status_of(c);
					{1'b0, REG_FIFO}, {1'b1, REG_FIFO}: if (rx_cnt[c] > 0) begin
						o.read_data = rx_mem[c][rx_tail[c]];
						rx_tail[c] = (rx_tail[c] + 1) % RxDepth;
						rx_cnt[c]--;
					end
					REG_ISR: o.read_data = isr_of();
					REG_CTU: begin
						phase++;
						o.read_data = 8'(counter_now() >> 8);
					end
					REG_CTL: begin
						phase++;
						o.read_data = 8'(counter_now());
					end
					REG_IVR: o.read_data = ivr;
					REG_OPC: o.read_data = 8'hFF;
					REG_STRT: begin
						running = 1'b1;
						ticks = '0;
						phase = '0;
						o.read_data = 8'hFF;
					end
					REG_STOP: begin
						running = 1'b0;
						o.read_data = 8'hFF;
					end
					default: o.read_data = 8'h00;
				endcase
			end
			CMD_WRITE: begin
				c = r.register_address[3];
				case (r.register_address)
					{1'b0, REG_MR}, {1'b1, REG_MR}: begin
						mode_reg[c][mode_ptr[c]] = d;
						mode_ptr[c] = 1'b1;
					end
					{1'b0, REG_CR}, {1'b1, REG_CR}: begin
						if (d[1:0] == 2'd1) rx_en[c] = 1'b1;
						else if (d[1:0] == 2'd2) rx_en[c] = 1'b0;
						if (d[3:2] == 2'd1) tx_en[c] = 1'b1;
						else if (d[3:2] == 2'd2) tx_en[c] = 1'b0;
						if (d[6:4] == 3'd1) mode_ptr[c] = 1'b0;
						else if (d[6:4] == 3'd2) begin
							rx_head[c] = 0;
							rx_tail[c] = 0;
							rx_cnt[c] = 0;
						end
					end
					{1'b0, REG_FIFO}, {1'b1, REG_FIFO}: begin
						if (loopback(c))
							rx_push(c, d);
						else if (tx_cnt[c] < TxDepth) begin
							tx_mem[c][tx_head[c]] = d;
							tx_head[c] = (tx_head[c] + 1) % TxDepth;
							tx_cnt[c]++;
						end
					end
					REG_ISR: imr = d;
					REG_CTU: preset[15:8] = d;
					REG_CTL: preset[7:0] = d;
					REG_IVR: ivr = d;
					default: ;
				endcase
			end
			CMD_LRX: if (!loopback(r.line_channel)) rx_push(r.line_channel, d);
			CMD_LTX: begin
				c = r.line_channel;
				if (tx_cnt[c] > 0) begin
					o.line_valid = 1'b1;
					o.line_byte = tx_mem[c][tx_tail[c]];
					tx_tail[c] = (tx_tail[c] + 1) % TxDepth;
					tx_cnt[c]--;
				end
			end
			CMD_TICK: if (running) ticks++;
			default: ;
		endcase
		o.irq = (isr_of() & imr) != 0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				rx_head[c] = 0; rx_tail[c] = 0; rx_cnt[c] = 0;
				tx_head[c] = 0; tx_tail[c] = 0; tx_cnt[c] = 0;
				mode_reg[c][0] = '0; mode_reg[c][1] = '0;
				mode_ptr[c] = 1'b0; rx_en[c] = 1'b0; tx_en[c] = 1'b0;
			end
			imr = '0;
			ivr = 8'h0F;
			preset = 16'hFFFF;
			running = 1'b0;
			ticks = '0;
			phase = '0;
			errors = 0;
			expected_rsp.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with none expected, actual %h", $time, rsp_item);
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					if (e.read_data !== rsp_item.read_data) begin
						$display("%0t: read_data expected %h actual %h", $time,
							e.read_data, rsp_item.read_data);
						errors++;
					end
					if (e.line_valid !== rsp_item.line_valid) begin
						$display("%0t: line_valid expected %b actual %b", $time,
							e.line_valid, rsp_item.line_valid);
						errors++;
					end
					if (e.line_byte !== rsp_item.line_byte) begin
						$display("%0t: line_byte expected %h actual %h", $time,
							e.line_byte, rsp_item.line_byte);
						errors++;
					end
					if (e.irq !== rsp_item.irq) begin
						$display("%0t: irq expected %b actual %b", $time, e.irq, rsp_item.irq);
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp.push_back(predict_response(req_item));
		end
	end
endmodule

[bench/dual_uart_register_model_core_tb.sv]
`timescale 1ns / 100ps
// Top of the dual UART register model bench: clock, reset, request stimulus
// and response stalls. Depends on duart_pkg, duart_if, duart_tb_pkg, duart_checker.
module dual_uart_register_model_core_tb;
	import duart_pkg::*;
	import duart_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending;
	logic done = 1'b0;
	int rsp_wait = 0;

	duart_req_if req ();
	duart_rsp_if rsp ();

	dual_uart_register_model_core uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	duart_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_item(req.payload),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.payload),
		.errors(errors), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
	end

	// response side: random stall per item
	always @(posedge clk) begin
		if (!done && arst_n) begin
			if (rsp.valid && rsp.ready) begin
				rsp.ready <= 1'b0;
				rsp_wait <= $urandom_range(0, 12);
			end else if (rsp.valid && !rsp.ready) begin
				if (rsp_wait == 0)
					rsp.ready <= 1'b1;
				else
					rsp_wait <= rsp_wait - 1;
			end
		end
	end

	// valid stays high into the next item when there is no gap
	task automatic send(req_t r, logic gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic req_t random_item();
		int k;
		logic [3:0] addr;
		k = $urandom_range(0, 99);
		addr = 4'($urandom_range(0, 15));
		// counter reads are slow; keep them rare
		if (k < 25)
			return make_item(CMD_READ, (addr inside {REG_CTU, REG_CTL}) &&
				$urandom_range(0, 3) != 0 ? {1'b0, REG_FIFO} : addr,
				8'($urandom), 1'($urandom));
		else if (k < 50)
			return make_item(CMD_WRITE, $urandom_range(0, 3) == 0 ? {1'b0, REG_CR} :
				($urandom_range(0, 1) ? {addr[3], REG_FIFO} : addr),
				addr[2:0] == REG_CR ? {1'b0, 3'($urandom_range(0, 2)), 4'($urandom)} :
				8'($urandom), 1'($urandom));
		else if (k < 68)
			return make_item(CMD_LRX, 4'($urandom), 8'($urandom), 1'($urandom));
		else if (k < 86)
			return make_item(CMD_LTX, 4'($urandom), 8'($urandom), 1'($urandom));
		else if (k < 97)
			return make_item(CMD_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
		return make_item(3'($urandom_range(5, 7)), 4'($urandom), 8'($urandom),
			1'($urandom));
	endfunction

	initial begin
		logic gaps;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send(make_item(CMD_READ, REG_IVR, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, REG_ISR, 8'hFF, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, {1'b0, REG_CR}, 8'h05, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, {1'b1, REG_CR}, 8'h05, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, {1'b0, REG_MR}, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, {1'b0, REG_MR}, 8'h80, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, {1'b0, REG_FIFO}, 8'hFF, 1'b0), 1'b0);
		send(make_item(CMD_LRX, 4'd0, 8'h55, 1'b0), 1'b0);
		send(make_item(CMD_READ, {1'b0, REG_SR}, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, {1'b0, REG_FIFO}, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, {1'b0, REG_FIFO}, 8'h00, 1'b0), 1'b0);
		for (int i = 0; i < 18; i++)
			send(make_item(CMD_WRITE, {1'b1, REG_FIFO}, 8'(i), 1'b0), 1'b0);
		send(make_item(CMD_LTX, 4'd0, 8'h00, 1'b1), 1'b0);
		send(make_item(CMD_LTX, 4'd0, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, REG_CTU, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_WRITE, REG_CTL, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, REG_STRT, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_TICK, 4'd0, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, REG_CTU, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, REG_CTL, 8'h00, 1'b0), 1'b0);
		send(make_item(CMD_READ, REG_STOP, 8'h00, 1'b0), 1'b0);
		send(make_item(3'd7, 4'd15, 8'hFF, 1'b1), 1'b0);
		drain();
		// random
		for (int i = 0; i < 1500; i++) begin
			gaps = (i / 200) % 2 == 0;
			send(random_item(), gaps);
			if (i == 700)
				drain();
		end
		drain();
		repeat (60) @(posedge clk);
		done = 1'b1;
		if (errors == 0 && pending == 0)
			$display("** dual_uart_register_model_core: PASSED **");
		else
			$display("** dual_uart_register_model_core: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** dual_uart_register_model_core: FAILED **");
		$finish;
	end
endmodule
